### rtl/sfc_pkg.sv
// shared constants, types and the crc byte step for the sample frame builder
package sfc_pkg;

    localparam int CHANNELS    = 4;
    localparam int SAMPLE_W    = 16;
    localparam int BYTE_W      = 8;
    localparam int DATA_BYTES  = 2 * CHANNELS;
    localparam int FRAME_BYTES = DATA_BYTES + 2;
    localparam int CNT_W       = $clog2(FRAME_BYTES);
    localparam int FRAME_W     = DATA_BYTES * BYTE_W;

    localparam logic [15:0] CRC_POLY_REFL = 16'hA001;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;

    typedef logic [CHANNELS-1:0][SAMPLE_W-1:0] sample_arr_t;

    // pending frame handed from the input register to the serializer
    typedef struct packed {
        logic        valid;
        sample_arr_t words;
    } hold_t;

    // one crc-16/modbus byte update, reflected, lsb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY_REFL;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

### rtl/sample_frame_crc16_builder.sv
// top level: four sample words in, ten-byte frame with crc-16/modbus out
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+-----------------------------
//  input    | sample_0, sample_1, sample_2, sample_3  | start high while busy low
//  result   | frame_byte, frame_end                   | out_valid, one word per cycle
//
// A frame is ten result words on consecutive cycles; the input word passes through
// the input register, the serializer's frame register and the result register.
// The byte sequencer sets the pace of frames; a following word is taken into the
// input register while the current frame is still going out.
// Reset clears the control state; no frame is in flight after it.
// The receiver cannot stall: each result word is shown for exactly one cycle.
module sample_frame_crc16_builder
    import sfc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [SAMPLE_W-1:0] sample_0,
    input  logic [SAMPLE_W-1:0] sample_1,
    input  logic [SAMPLE_W-1:0] sample_2,
    input  logic [SAMPLE_W-1:0] sample_3,
    output logic                out_valid,
    output logic [BYTE_W-1:0]   frame_byte,
    output logic                frame_end
);

    sample_arr_t words;
    hold_t       hold;
    logic        take;

    // channel order: sample_0 sent first
    assign words[0] = sample_0;
    assign words[1] = sample_1;
    assign words[2] = sample_2;
    assign words[3] = sample_3;

    sfc_hold u_hold (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .words (words),
        .take  (take),
        .busy  (busy),
        .hold  (hold)
    );

    sfc_serializer u_ser (
        .clk        (clk),
        .rst_n      (rst_n),
        .hold       (hold),
        .take       (take),
        .out_valid  (out_valid),
        .frame_byte (frame_byte),
        .frame_end  (frame_end)
    );

endmodule

### rtl/sfc_hold.sv
// one-entry input register that takes a word while the previous frame streams out
module sfc_hold
    import sfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  sample_arr_t words,
    input  logic        take,
    output logic        busy,
    output hold_t       hold
);

    logic        valid_reg;
    logic        valid_next;
    sample_arr_t words_reg;
    logic        accept;

    // free when empty or when the serializer takes the entry this cycle
    assign busy   = valid_reg & ~take;
    assign accept = start & ~busy;

    // occupancy
    always_comb
    begin
        if (take)
            valid_next = accept;
        else
            valid_next = valid_reg | accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (accept)
            words_reg <= words;
    end

    assign hold.valid = valid_reg;
    assign hold.words = words_reg;

endmodule

### rtl/sfc_serializer.sv
// byte sequencer: sends data bytes, folds them into the crc, then sends the crc
module sfc_serializer
    import sfc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  hold_t             hold,
    output logic              take,
    output logic              out_valid,
    output logic [BYTE_W-1:0] frame_byte,
    output logic              frame_end
);

    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(FRAME_BYTES - 1);
    localparam logic [CNT_W-1:0] CRC_IDX  = CNT_W'(DATA_BYTES);

    logic               active_reg;
    logic               active_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [FRAME_W-1:0] frame_reg;
    logic [15:0]        crc_reg;
    logic               valid_reg;
    logic [BYTE_W-1:0]  byte_reg;
    logic               end_reg;
    logic               last;
    logic               is_data;
    logic [BYTE_W-1:0]  byte_sel;

    assign last    = active_reg & (cnt_reg == LAST_IDX);
    assign take    = hold.valid & (~active_reg | last);
    assign is_data = cnt_reg < CRC_IDX;

    // byte chosen for this cycle
    always_comb
    begin
        if (is_data)
            byte_sel = frame_reg[BYTE_W-1:0];
        else if (cnt_reg == CRC_IDX)
            byte_sel = crc_reg[7:0];
        else
            byte_sel = crc_reg[15:8];
    end

    always_comb
    begin
        if (take)
            active_next = 1'b1;
        else if (last)
            active_next = 1'b0;
        else
            active_next = active_reg;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            valid_reg  <= active_reg;
        end
    end

    // frame shifter, byte counter and running crc
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            frame_reg <= FRAME_W'(hold.words);
            cnt_reg   <= '0;
            crc_reg   <= CRC_INIT;
        end
        else if (active_reg)
        begin
            frame_reg <= frame_reg >> BYTE_W;
            cnt_reg   <= cnt_reg + 1'b1;
            if (is_data)
                crc_reg <= crc_byte(crc_reg, frame_reg[BYTE_W-1:0]);
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_sel;
        end_reg  <= last;
    end

    assign out_valid  = valid_reg;
    assign frame_byte = byte_reg;
    assign frame_end  = end_reg;

endmodule
